[design/dtt_pkg.sv]
`timescale 1ns / 1ps

package dtt_pkg;

  localparam logic [2:0] CMD_ADD       = 3'd0;
  localparam logic [2:0] CMD_ADD_AFTER = 3'd1;
  localparam logic [2:0] CMD_CLEAR     = 3'd2;
  localparam logic [2:0] CMD_REPLACE   = 3'd3;
  localparam logic [2:0] CMD_CLEAR_ALL = 3'd4;
  localparam logic [2:0] CMD_TICK      = 3'd5;

  localparam logic [1:0] KIND_ADDED    = 2'd0;
  localparam logic [1:0] KIND_REJECTED = 2'd1;
  localparam logic [1:0] KIND_FIRED    = 2'd2;
  localparam logic [1:0] KIND_DONE     = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] timer_id;
    logic [23:0] delay_ms;
    logic [7:0]  client_id;
    logic [7:0]  channel_state;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_timer_id;
    logic [7:0]  out_client_id;
    logic [7:0]  out_channel_state;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [31:0] deadline;
    logic [15:0] tag;
    logic [7:0]  client;
    logic [7:0]  payload;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_SCAN,
    ST_EXEC
  } state_t;

endpackage

[design/dtt_entry_ram.sv]
`timescale 1ns / 1ps

module dtt_entry_ram #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output dtt_pkg::entry_t            rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  dtt_pkg::entry_t            wr_data
);
  import dtt_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/dtt_slot_mod.sv]
`timescale 1ns / 1ps

// slot = value mod DEPTH in two stages: reciprocal multiply, then
// remainder with one correction step (quotient estimate is low by at most 1).
module dtt_slot_mod #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     start,
  input  logic [15:0]              value,
  output logic [$clog2(DEPTH)-1:0] slot
);
  import dtt_pkg::*;

  localparam int          SW    = $clog2(DEPTH);
  localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / DEPTH);
  localparam logic [15:0] DEP16 = 16'(DEPTH);

  logic [15:0] x;
  logic [15:0] quot;
  logic [47:0] prod;
  logic [15:0] qd;
  logic [15:0] rem;
  logic [15:0] rem_fix;

  assign prod = 48'(value) * 48'(RECIP);

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= value;
      quot <= prod[47:32];
    end
  end

  always_comb begin
    qd      = quot * DEP16;
    rem     = x - qd;
    rem_fix = (rem >= DEP16) ? rem - DEP16 : rem;
  end

  always_ff @(posedge clk) begin
    slot <= rem_fix[SW-1:0];
  end

endmodule

[design/deadline_timer_table.sv]
// Table of DEPTH one-shot deadline timers. Timer id N lives in slot N mod DEPTH;
// deadlines, ids, clients and payloads sit in one single-port-read entry RAM,
// live flags in flip-flops. add, add-after, clear, replace, clear-all and
// unknown codes pass through accept together with the first slot-reduction
// stage, then the second slot-reduction stage, RAM read and update; the update
// waits while the output is stalled. A tick walks the window of the last 2*DEPTH
// issued ids, oldest first, one RAM read per cycle while no fired word waits on
// a stalled output, emitting each due timer as it is found and then a done word.
// One input word is in work at a time; in_stall is high until its last result
// is registered.
`timescale 1ns / 1ps

module deadline_timer_table #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  dtt_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output dtt_pkg::out_word_t  out_word
);
  import dtt_pkg::*;

  localparam int              SW        = $clog2(DEPTH);
  localparam int              CW        = $clog2(2 * DEPTH + 1);
  localparam logic [15:0]     WIN       = 16'(2 * DEPTH);
  localparam logic [CW-1:0]   WIN_CNT   = CW'(2 * DEPTH);
  localparam logic [SW-1:0]   LAST_SLOT = SW'(DEPTH - 1);

  state_t            state;
  state_t            state_next;
  in_word_t          cmd;
  logic [DEPTH-1:0]  valid;
  logic [DEPTH-1:0]  valid_next;
  logic [15:0]       next_id;
  logic [SW-1:0]     next_slot;
  logic [31:0]       current_time;

  logic [15:0]       scan_tag;
  logic [SW-1:0]     scan_slot;
  logic [CW-1:0]     scan_cnt;
  logic              chk_v;
  logic [15:0]       chk_tag;
  logic [SW-1:0]     chk_slot;

  out_word_t         out_next;
  logic              out_load;

  logic              accept;
  logic              out_free;
  logic [15:0]       mod_value;
  logic [SW-1:0]     ref_slot;
  logic              rd_en;
  logic [SW-1:0]     rd_addr;
  entry_t            rd_entry;
  logic              wr_en;
  logic [SW-1:0]     wr_addr;
  entry_t            wr_data;

  logic              live_ref;
  logic              slot_busy;
  logic [31:0]       base;
  logic [32:0]       sum;
  logic [31:0]       new_deadline;
  logic              issue;
  logic              fire;
  logic              advance;
  logic              scan_done;
  logic              id_inc;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // tick starts its walk at the oldest id that can still be live
  assign mod_value = (in_word.command == CMD_TICK) ? next_id - WIN : in_word.timer_id;

  dtt_slot_mod #(.DEPTH(DEPTH)) u_slot_mod (
    .clk   (clk),
    .start (accept),
    .value (mod_value),
    .slot  (ref_slot)
  );

  dtt_entry_ram #(.DEPTH(DEPTH)) u_entry_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_entry),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_comb begin
    live_ref     = valid[ref_slot] && (rd_entry.tag == cmd.timer_id);
    slot_busy    = valid[next_slot];
    base         = (cmd.command == CMD_ADD_AFTER && live_ref) ? rd_entry.deadline
                                                              : current_time;
    sum          = {1'b0, base} + {9'b0, cmd.delay_ms};
    new_deadline = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

    issue     = (scan_cnt != WIN_CNT);
    fire      = chk_v && valid[chk_slot] && (rd_entry.tag == chk_tag)
                && (cmd.now_ms >= rd_entry.deadline);
    advance   = !(fire && !out_free);
    scan_done = !issue && !chk_v;

    rd_addr = (state == ST_SCAN) ? scan_slot : ref_slot;
    rd_en   = (state == ST_READ) || (state == ST_SCAN && advance && issue);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_MOD;
      end
      ST_MOD: begin
        state_next = ST_READ;
      end
      ST_READ: begin
        state_next = (cmd.command == CMD_TICK) ? ST_SCAN : ST_EXEC;
      end
      ST_SCAN: begin
        if (scan_done) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = next_slot;
    wr_data    = '{deadline: new_deadline, tag: next_id,
                   client: cmd.client_id, payload: cmd.channel_state};
    valid_next = valid;
    out_load   = 1'b0;
    out_next   = '{kind: KIND_DONE, out_timer_id: 16'd0, out_client_id: 8'd0,
                   out_channel_state: 8'd0, last: 1'b1};
    id_inc     = 1'b0;
    case (state)
      ST_EXEC: begin
        if (out_free) begin
          out_load = 1'b1;
          case (cmd.command) inside
            CMD_ADD, CMD_ADD_AFTER: begin
              out_next.out_timer_id = next_id;
              if (slot_busy) begin
                out_next.kind = KIND_REJECTED;
              end else begin
                out_next.kind         = KIND_ADDED;
                wr_en                 = 1'b1;
                valid_next[next_slot] = 1'b1;
                id_inc                = 1'b1;
              end
            end
            CMD_CLEAR: begin
              if (live_ref) valid_next[ref_slot] = 1'b0;
            end
            CMD_REPLACE: begin
              if (live_ref) begin
                wr_en   = 1'b1;
                wr_addr = ref_slot;
                wr_data = '{deadline: rd_entry.deadline, tag: rd_entry.tag,
                            client: cmd.client_id, payload: cmd.channel_state};
              end
            end
            CMD_CLEAR_ALL: begin
              valid_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (fire && out_free) begin
          out_load             = 1'b1;
          out_next             = '{kind: KIND_FIRED, out_timer_id: chk_tag,
                                   out_client_id: rd_entry.client,
                                   out_channel_state: rd_entry.payload, last: 1'b0};
          valid_next[chk_slot] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      valid        <= '0;
      next_id      <= 16'd0;
      next_slot    <= '0;
      current_time <= 32'd0;
      scan_cnt     <= WIN_CNT;
      chk_v        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      valid <= valid_next;

      if (accept && in_word.command == CMD_TICK) begin
        current_time <= in_word.now_ms;
      end

      if (id_inc) begin
        next_id <= next_id + 16'd1;
        if (next_id == 16'hFFFF || next_slot == LAST_SLOT) begin
          next_slot <= '0;
        end else begin
          next_slot <= next_slot + SW'(1);
        end
      end

      if (state == ST_READ) begin
        scan_cnt <= '0;
        chk_v    <= 1'b0;
      end else if (state == ST_SCAN && advance) begin
        chk_v <= issue;
        if (issue) scan_cnt <= scan_cnt + CW'(1);
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk pointer and check stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= in_word;
    end
    if (state == ST_READ) begin
      scan_tag  <= next_id - WIN;
      scan_slot <= ref_slot;
    end else if (state == ST_SCAN && advance && issue) begin
      chk_tag  <= scan_tag;
      chk_slot <= scan_slot;
      scan_tag <= scan_tag + 16'd1;
      if (scan_tag == 16'hFFFF || scan_slot == LAST_SLOT) begin
        scan_slot <= '0;
      end else begin
        scan_slot <= scan_slot + SW'(1);
      end
    end
    if (out_load) begin
      out_word <= out_next;
    end
  end

endmodule
